### sv/swhr_pkg.sv
`default_nettype none

package swhr_pkg;

    localparam int PULSE_PAIRS = 41;
    localparam int AW          = $clog2(PULSE_PAIRS);
    localparam int SUM_W       = 22;
    localparam int THR_W       = 17;
    localparam int FRAME_W     = 40;

    localparam logic [1:0] CFG_WAKE_HIGH = 2'd0;
    localparam logic [1:0] CFG_START_LOW = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_RESPONSE = 2'd1;
    localparam logic [1:0] ST_PULSE_TMO   = 2'd2;
    localparam logic [1:0] ST_CHECKSUM    = 2'd3;

    localparam logic [23:0] WAKE_HIGH_RST = 24'd500000;
    localparam logic [23:0] START_LOW_RST = 24'd20000;
    localparam logic [15:0] TIMEOUT_RST   = 16'd32000;

    // floor(2^16 / 5), used for the divide by the pulse count
    localparam logic [13:0] RECIP_5 = 14'd13107;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAKE,
        PH_START,
        PH_WAIT,
        PH_LOW,
        PH_HIGH
    } t_phase;

    typedef enum logic [2:0] {
        DS_IDLE,
        DS_MUL,
        DS_THR,
        DS_WALK,
        DS_DONE
    } t_dec_state;

    typedef struct packed {
        logic line_level;
        logic start_req;
    } t_in_word;

    typedef struct packed {
        logic               drive_enable;
        logic               drive_level;
        logic               busy_res;
        logic               done_res;
        logic [1:0]         status;
        logic [15:0]        humidity_tenths;
        logic signed [15:0] temperature_tenths;
    } t_out_word;

    typedef struct packed {
        logic               done;
        logic               ok;
        logic [15:0]        humidity;
        logic signed [15:0] temperature;
    } t_dec_res;

endpackage

`default_nettype wire

### sv/swhr_ram.sv
`default_nettype none

module swhr_ram (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [swhr_pkg::AW-1:0] i_waddr,
    input  wire logic [15:0]            i_wdata,
    input  wire logic [swhr_pkg::AW-1:0] i_raddr,
    output logic [15:0]                 o_rdata
);
    import swhr_pkg::*;

    logic [15:0] r_mem [PULSE_PAIRS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### sv/swhr_decode.sv
`default_nettype none

module swhr_decode (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [swhr_pkg::SUM_W-1:0] i_sum,
    output logic [swhr_pkg::AW-1:0]        o_rd_addr,
    input  wire logic [15:0]               i_rd_data,
    input  wire logic                      i_ack,
    output swhr_pkg::t_dec_res             o_res
);
    import swhr_pkg::*;

    t_dec_state r_st, n_st;
    logic [AW-1:0]      r_idx;
    logic               r_dv;
    logic [SUM_W-4:0]   r_s3;
    logic [32:0]        r_prod;
    logic [THR_W-1:0]   r_thr;
    logic [FRAME_W-1:0] r_bits;

    logic               issue;
    logic [THR_W-1:0]   q0;
    logic [19:0]        rem;
    logic [THR_W-1:0]   thr;
    logic [7:0]         b0, b1, b2, b3, b4;
    logic [7:0]         csum;
    logic [15:0]        mag;

    assign issue     = (r_st == DS_WALK) && (r_idx <= AW'(PULSE_PAIRS - 1));
    assign o_rd_addr = r_idx;

    // divide by 40: shift right by 3, reciprocal of 5, then fix up the remainder
    always_comb begin
        q0  = r_prod[32:16];
        rem = 20'(r_s3) - 20'(q0) * 20'd5;
        if (rem >= 20'd10) begin
            thr = q0 + THR_W'(2);
        end else if (rem >= 20'd5) begin
            thr = q0 + THR_W'(1);
        end else begin
            thr = q0;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            DS_IDLE: begin
                if (i_start) n_st = DS_MUL;
            end
            DS_MUL:  n_st = DS_THR;
            DS_THR:  n_st = DS_WALK;
            DS_WALK: begin
                if (!issue && !r_dv) n_st = DS_DONE;
            end
            DS_DONE: begin
                if (i_ack) n_st = DS_IDLE;
            end
            default: n_st = DS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= DS_IDLE;
            r_dv  <= 1'b0;
            r_idx <= '0;
        end else begin
            r_st <= n_st;
            r_dv <= issue;
            if (r_st == DS_THR) begin
                r_idx <= AW'(1);
            end else if (issue) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == DS_IDLE && i_start) begin
            r_s3 <= i_sum[SUM_W-1:3];
        end
        if (r_st == DS_MUL) begin
            r_prod <= 33'(r_s3) * 33'(RECIP_5);
        end
        if (r_st == DS_THR) begin
            r_thr  <= thr;
            r_bits <= '0;
        end else if (r_dv) begin
            r_bits <= {r_bits[FRAME_W-2:0], ({1'b0, i_rd_data} >= r_thr)};
        end
    end

    always_comb begin
        b0   = r_bits[39:32];
        b1   = r_bits[31:24];
        b2   = r_bits[23:16];
        b3   = r_bits[15:8];
        b4   = r_bits[7:0];
        csum = b0 + b1 + b2 + b3;
        mag  = {1'b0, b2[6:0], b3};
        o_res.done        = (r_st == DS_DONE);
        o_res.ok          = (b4 == csum);
        o_res.humidity    = {b0, b1};
        o_res.temperature = b2[7] ? -mag : mag;
    end

endmodule

`default_nettype wire

### sv/single_wire_humidity_sensor_reader_core.sv
// one result word per accepted input word, registered in the cycle after acceptance
// throughput one word per cycle while the output side keeps up and no decode is pending
// the word that ends the last pulse pair gets its result from a decode instead: threshold multiply,
// then a 40-entry read walk of the high-width memory, one entry per cycle
// reset is synchronous active low, clears control and loads default timings; memory not reset
`default_nettype none

module single_wire_humidity_sensor_reader_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire swhr_pkg::t_in_word  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output swhr_pkg::t_out_word      o_out,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [23:0]         i_cfg_data
);
    import swhr_pkg::*;

    logic [23:0] r_wake_high, r_start_low;
    logic [15:0] r_timeout;

    t_phase r_ph, n_ph;
    logic [23:0]      r_pt, n_pt;
    logic [AW-1:0]    r_pn, n_pn;
    logic [15:0]      r_ptk, n_ptk;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [15:0]      r_hum;
    logic signed [15:0] r_temp;
    logic             r_wait_dec;
    logic             r_out_vld;
    t_out_word        r_out;

    logic       n_done, n_dec, n_we;
    logic [1:0] n_stat;
    logic [15:0] ptk_inc;
    logic       accept, out_free;
    t_out_word  n_out, dec_out;
    t_dec_res   dec_res;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;

    assign out_free    = !r_out_vld || i_out_ready;
    assign o_in_ready  = !r_wait_dec && out_free;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign ptk_inc     = r_ptk + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wake_high <= WAKE_HIGH_RST;
            r_start_low <= START_LOW_RST;
            r_timeout   <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WAKE_HIGH: r_wake_high <= i_cfg_data;
                CFG_START_LOW: r_start_low <= i_cfg_data;
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // next state of the tick sequencer
    always_comb begin
        n_ph   = r_ph;
        n_pt   = r_pt;
        n_pn   = r_pn;
        n_ptk  = r_ptk;
        n_sum  = r_sum;
        n_done = 1'b0;
        n_stat = ST_OK;
        n_dec  = 1'b0;
        n_we   = 1'b0;
        unique case (r_ph)
            PH_IDLE: begin
                if (i_in.start_req) begin
                    n_pn  = '0;
                    n_ptk = '0;
                    n_sum = '0;
                    if (r_wake_high != '0) begin
                        n_ph = PH_WAKE;
                        n_pt = 24'd1;
                    end else if (r_start_low != '0) begin
                        n_ph = PH_START;
                        n_pt = 24'd1;
                    end else begin
                        n_ph = PH_WAIT;
                        n_pt = '0;
                    end
                end
            end
            PH_WAKE: begin
                if (r_pt >= r_wake_high) begin
                    if (r_start_low != '0) begin
                        n_ph = PH_START;
                        n_pt = 24'd1;
                    end else begin
                        n_ph  = PH_WAIT;
                        n_pt  = '0;
                        n_ptk = '0;
                    end
                end else begin
                    n_pt = r_pt + 24'd1;
                end
            end
            PH_START: begin
                if (r_pt >= r_start_low) begin
                    n_ph  = PH_WAIT;
                    n_pt  = '0;
                    n_ptk = '0;
                end else begin
                    n_pt = r_pt + 24'd1;
                end
            end
            PH_WAIT: begin
                if (i_in.line_level) begin
                    n_ptk = ptk_inc;
                    if (ptk_inc >= r_timeout) begin
                        n_done = 1'b1;
                        n_stat = ST_NO_RESPONSE;
                    end
                end else begin
                    n_ph  = PH_LOW;
                    n_pn  = '0;
                    n_ptk = 16'd1;
                    if (16'd1 >= r_timeout) begin
                        n_done = 1'b1;
                        n_stat = ST_PULSE_TMO;
                    end
                end
            end
            PH_LOW: begin
                if (!i_in.line_level) begin
                    n_ptk = ptk_inc;
                    if (ptk_inc >= r_timeout) begin
                        n_done = 1'b1;
                        n_stat = ST_PULSE_TMO;
                    end
                end else begin
                    if (r_pn != '0) begin
                        n_sum = r_sum + SUM_W'(r_ptk);
                    end
                    n_ph  = PH_HIGH;
                    n_ptk = 16'd1;
                    if (16'd1 >= r_timeout) begin
                        n_done = 1'b1;
                        n_stat = ST_PULSE_TMO;
                    end
                end
            end
            PH_HIGH: begin
                if (i_in.line_level) begin
                    n_ptk = ptk_inc;
                    if (ptk_inc >= r_timeout) begin
                        n_done = 1'b1;
                        n_stat = ST_PULSE_TMO;
                    end
                end else begin
                    n_we = 1'b1;
                    n_pn = r_pn + AW'(1);
                    if (r_pn == AW'(PULSE_PAIRS - 1)) begin
                        n_dec = 1'b1;
                        n_ph  = PH_IDLE;
                    end else begin
                        n_ph  = PH_LOW;
                        n_ptk = 16'd1;
                        if (16'd1 >= r_timeout) begin
                            n_done = 1'b1;
                            n_stat = ST_PULSE_TMO;
                        end
                    end
                end
            end
            default: n_ph = PH_IDLE;
        endcase
        if (n_done) begin
            n_ph = PH_IDLE;
        end
    end

    // result word of an ordinary tick and of a finished decode
    always_comb begin
        n_out.drive_enable       = (n_ph == PH_WAKE) || (n_ph == PH_START);
        n_out.drive_level        = (n_ph == PH_WAKE);
        n_out.busy_res           = (n_ph != PH_IDLE);
        n_out.done_res           = n_done;
        n_out.status             = n_stat;
        n_out.humidity_tenths    = r_hum;
        n_out.temperature_tenths = r_temp;

        dec_out.drive_enable       = 1'b0;
        dec_out.drive_level        = 1'b0;
        dec_out.busy_res           = 1'b0;
        dec_out.done_res           = 1'b1;
        dec_out.status             = dec_res.ok ? ST_OK : ST_CHECKSUM;
        dec_out.humidity_tenths    = dec_res.ok ? dec_res.humidity : r_hum;
        dec_out.temperature_tenths = dec_res.ok ? dec_res.temperature : r_temp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph       <= PH_IDLE;
            r_pt       <= '0;
            r_pn       <= '0;
            r_ptk      <= '0;
            r_sum      <= '0;
            r_hum      <= '0;
            r_temp     <= '0;
            r_wait_dec <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (accept) begin
                r_ph  <= n_ph;
                r_pt  <= n_pt;
                r_pn  <= n_pn;
                r_ptk <= n_ptk;
                r_sum <= n_sum;
            end
            if (dec_res.done && out_free) begin
                r_wait_dec <= 1'b0;
                if (dec_res.ok) begin
                    r_hum  <= dec_res.humidity;
                    r_temp <= dec_res.temperature;
                end
            end else if (accept && n_dec) begin
                r_wait_dec <= 1'b1;
            end
            if (dec_res.done && out_free) begin
                r_out_vld <= 1'b1;
            end else if (accept && !n_dec) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_res.done && out_free) begin
            r_out <= dec_out;
        end else if (accept && !n_dec) begin
            r_out <= n_out;
        end
    end

    swhr_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && n_we),
        .i_waddr (r_pn),
        .i_wdata (r_ptk),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    swhr_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept && n_dec),
        .i_sum     (r_sum),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .i_ack     (out_free),
        .o_res     (dec_res)
    );

endmodule

`default_nettype wire
